// File: rtl/core/isl_pkg.sv
// Shared constants and command codes for the indexed shift list.
package isl_pkg;

   localparam int CAPACITY_DEFAULT  = 64;
   localparam int WORD_BITS_DEFAULT = 32;
   localparam int MAX_WORD_BITS     = 64;

   localparam int OPCODE_BITS    = 4;
   localparam int POSITION_BITS  = 6;
   localparam int PORT_WORD_BITS = 32;
   localparam int ENTRY_BITS     = 7;

   localparam logic [OPCODE_BITS-1:0] OP_GET        = 4'd0;
   localparam logic [OPCODE_BITS-1:0] OP_SET        = 4'd1;
   localparam logic [OPCODE_BITS-1:0] OP_PUSH_BACK  = 4'd2;
   localparam logic [OPCODE_BITS-1:0] OP_PUSH_FRONT = 4'd3;
   localparam logic [OPCODE_BITS-1:0] OP_INSERT     = 4'd4;
   localparam logic [OPCODE_BITS-1:0] OP_POP_BACK   = 4'd5;
   localparam logic [OPCODE_BITS-1:0] OP_POP_FRONT  = 4'd6;
   localparam logic [OPCODE_BITS-1:0] OP_POP_AT     = 4'd7;
   localparam logic [OPCODE_BITS-1:0] OP_CLEAR      = 4'd8;
   localparam logic [OPCODE_BITS-1:0] OP_GET_FRONT  = 4'd9;
   localparam logic [OPCODE_BITS-1:0] OP_GET_BACK   = 4'd10;

endpackage

// File: rtl/core/isl_if.sv
// Command and response channel interfaces of the indexed shift list.
interface isl_req_if;
   logic                               valid;
   logic                               ready;
   logic [isl_pkg::OPCODE_BITS-1:0]    opcode;
   logic [isl_pkg::POSITION_BITS-1:0]  position;
   logic [isl_pkg::PORT_WORD_BITS-1:0] word_in;

   modport source (output valid, output opcode, output position, output word_in,
                   input ready);
   modport sink (input valid, input opcode, input position, input word_in,
                 output ready);
endinterface

interface isl_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               ok;
   logic [isl_pkg::PORT_WORD_BITS-1:0] word_out;
   logic [isl_pkg::ENTRY_BITS-1:0]     entries;

   modport source (output valid, output ok, output word_out, output entries,
                   input ready);
   modport sink (input valid, input ok, input word_out, input entries,
                 output ready);
endinterface

// File: rtl/core/indexed_shift_list.sv
// Top level of the indexed shift list: command sequencer around the entry storage.
// Set, push_back, clear, push_front on an empty list and rejected commands finish from idle.
// Reads (get, get_front, get_back, pop_back) answer from the read state with the stored word.
// Insert and push_front shift entries up, then write the word; pops at p shift entries down.
// The shift moves one entry per cycle; a response held by the receiver stalls the next command.
// Reset clears the entry count and the control state; stored words stay undefined.
module indexed_shift_list #(
   parameter int CAPACITY  = isl_pkg::CAPACITY_DEFAULT,
   parameter int WORD_BITS = isl_pkg::WORD_BITS_DEFAULT
) (
   input logic clock,
   input logic reset,
   isl_req_if.sink   req_if,
   isl_rsp_if.source rsp_if
);
   import isl_pkg::*;

   localparam int AW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > POSITION_BITS) ? CW : POSITION_BITS;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_READ   = 3'd1;
   localparam logic [2:0] ST_UP     = 3'd2;
   localparam logic [2:0] ST_PUT    = 3'd3;
   localparam logic [2:0] ST_DFIRST = 3'd4;
   localparam logic [2:0] ST_DOWN   = 3'd5;
   localparam logic [2:0] ST_FIN    = 3'd6;

   logic [2:0]           state_ff, state_in;
   logic [CW-1:0]        fill_ff, fill_in;
   logic [AW-1:0]        pos_ff, pos_in;
   logic [AW-1:0]        dst_ff, dst_in;
   logic [WORD_BITS-1:0] word_ff, word_in;
   logic                 pend_ok_ff, pend_ok_in;
   logic [WORD_BITS-1:0] pend_word_ff, pend_word_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_ok_ff, rsp_ok_in;
   logic [PORT_WORD_BITS-1:0] rsp_word_ff, rsp_word_in;
   logic [ENTRY_BITS-1:0]     rsp_entries_ff, rsp_entries_in;

   logic                 mem_we, mem_re;
   logic [AW-1:0]        mem_waddr, mem_raddr;
   logic [WORD_BITS-1:0] mem_wdata, rd_data;

   logic                 accept, out_free, done, load;
   logic                 res_ok;
   logic [WORD_BITS-1:0] res_word;
   logic                 in_range, full, empty;
   logic [AW-1:0]        pos_addr, fill_addr, last_addr;
   logic [WORD_BITS-1:0] word_masked;

   isl_store #(
      .DEPTH(CAPACITY),
      .WIDTH(WORD_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (rd_data)
   );

   assign req_if.ready = (state_ff == ST_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;

   assign in_range    = CMPW'(req_if.position) < CMPW'(fill_ff);
   assign full        = (fill_ff == CW'(CAPACITY));
   assign empty       = (fill_ff == '0);
   assign pos_addr    = AW'(req_if.position);
   assign fill_addr   = AW'(fill_ff);
   assign last_addr   = AW'(fill_ff - CW'(1));
   assign word_masked = WORD_BITS'(MAX_WORD_BITS'(req_if.word_in));

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      pos_in       = pos_ff;
      dst_in       = dst_ff;
      word_in      = word_ff;
      pend_ok_in   = pend_ok_ff;
      pend_word_in = pend_word_ff;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = '0;
      mem_re       = 1'b0;
      mem_raddr    = '0;
      done         = 1'b0;
      res_ok       = 1'b0;
      res_word     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pos_in  = pos_addr;
               word_in = word_masked;
               unique case (req_if.opcode)
                  OP_GET: begin
                     if (in_range) begin
                        mem_re    = 1'b1;
                        mem_raddr = pos_addr;
                        state_in  = ST_READ;
                     end else begin
                        done = 1'b1;
                     end
                  end
                  OP_SET: begin
                     done = 1'b1;
                     if (in_range) begin
                        mem_we    = 1'b1;
                        mem_waddr = pos_addr;
                        mem_wdata = word_masked;
                        res_ok    = 1'b1;
                     end
                  end
                  OP_PUSH_BACK: begin
                     done = 1'b1;
                     if (!full) begin
                        mem_we    = 1'b1;
                        mem_waddr = fill_addr;
                        mem_wdata = word_masked;
                        fill_in   = fill_ff + CW'(1);
                        res_ok    = 1'b1;
                     end
                  end
                  OP_PUSH_FRONT: begin
                     if (full) begin
                        done = 1'b1;
                     end else if (empty) begin
                        mem_we    = 1'b1;
                        mem_waddr = '0;
                        mem_wdata = word_masked;
                        fill_in   = fill_ff + CW'(1);
                        done      = 1'b1;
                        res_ok    = 1'b1;
                     end else begin
                        mem_re    = 1'b1;
                        mem_raddr = last_addr;
                        dst_in    = fill_addr;
                        pos_in    = '0;
                        fill_in   = fill_ff + CW'(1);
                        state_in  = ST_UP;
                     end
                  end
                  OP_INSERT: begin
                     if (in_range && !full) begin
                        mem_re    = 1'b1;
                        mem_raddr = last_addr;
                        dst_in    = fill_addr;
                        fill_in   = fill_ff + CW'(1);
                        state_in  = ST_UP;
                     end else begin
                        done = 1'b1;
                     end
                  end
                  OP_POP_BACK: begin
                     if (!empty) begin
                        mem_re    = 1'b1;
                        mem_raddr = last_addr;
                        fill_in   = fill_ff - CW'(1);
                        state_in  = ST_READ;
                     end else begin
                        done = 1'b1;
                     end
                  end
                  OP_POP_FRONT: begin
                     if (!empty) begin
                        mem_re    = 1'b1;
                        mem_raddr = '0;
                        pos_in    = '0;
                        fill_in   = fill_ff - CW'(1);
                        state_in  = ST_DFIRST;
                     end else begin
                        done = 1'b1;
                     end
                  end
                  OP_POP_AT: begin
                     if (in_range) begin
                        mem_re    = 1'b1;
                        mem_raddr = pos_addr;
                        fill_in   = fill_ff - CW'(1);
                        state_in  = ST_DFIRST;
                     end else begin
                        done = 1'b1;
                     end
                  end
                  OP_CLEAR: begin
                     fill_in = '0;
                     done    = 1'b1;
                     res_ok  = 1'b1;
                  end
                  OP_GET_FRONT: begin
                     if (!empty) begin
                        mem_re    = 1'b1;
                        mem_raddr = '0;
                        state_in  = ST_READ;
                     end else begin
                        done = 1'b1;
                     end
                  end
                  OP_GET_BACK: begin
                     if (!empty) begin
                        mem_re    = 1'b1;
                        mem_raddr = last_addr;
                        state_in  = ST_READ;
                     end else begin
                        done = 1'b1;
                     end
                  end
                  default: begin
                     done = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            done     = 1'b1;
            res_ok   = 1'b1;
            res_word = rd_data;
         end
         ST_UP: begin
            mem_we    = 1'b1;
            mem_waddr = dst_ff;
            mem_wdata = rd_data;
            if ((dst_ff - AW'(1)) > pos_ff) begin
               mem_re    = 1'b1;
               mem_raddr = dst_ff - AW'(2);
               dst_in    = dst_ff - AW'(1);
            end else begin
               state_in = ST_PUT;
            end
         end
         ST_PUT: begin
            mem_we    = 1'b1;
            mem_waddr = pos_ff;
            mem_wdata = word_ff;
            done      = 1'b1;
            res_ok    = 1'b1;
         end
         ST_DFIRST: begin
            pend_word_in = rd_data;
            if (CW'(pos_ff) < fill_ff) begin
               mem_re    = 1'b1;
               mem_raddr = pos_ff + AW'(1);
               dst_in    = pos_ff;
               state_in  = ST_DOWN;
            end else begin
               done     = 1'b1;
               res_ok   = 1'b1;
               res_word = rd_data;
            end
         end
         ST_DOWN: begin
            mem_we    = 1'b1;
            mem_waddr = dst_ff;
            mem_wdata = rd_data;
            if ((CW'(dst_ff) + CW'(1)) < fill_ff) begin
               mem_re    = 1'b1;
               mem_raddr = dst_ff + AW'(2);
               dst_in    = dst_ff + AW'(1);
            end else begin
               done     = 1'b1;
               res_ok   = 1'b1;
               res_word = pend_word_ff;
            end
         end
         ST_FIN: begin
            done     = 1'b1;
            res_ok   = pend_ok_ff;
            res_word = pend_word_ff;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      load = 1'b0;
      if (done) begin
         if (out_free) begin
            load     = 1'b1;
            state_in = ST_IDLE;
         end else begin
            pend_ok_in   = res_ok;
            pend_word_in = res_word;
            state_in     = ST_FIN;
         end
      end
   end

   always_comb begin
      rsp_ok_in      = rsp_ok_ff;
      rsp_word_in    = rsp_word_ff;
      rsp_entries_in = rsp_entries_ff;
      if (load) begin
         rsp_valid_in   = 1'b1;
         rsp_ok_in      = res_ok;
         rsp_word_in    = PORT_WORD_BITS'(MAX_WORD_BITS'(res_word));
         rsp_entries_in = ENTRY_BITS'(fill_in);
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff         <= pos_in;
      dst_ff         <= dst_in;
      word_ff        <= word_in;
      pend_ok_ff     <= pend_ok_in;
      pend_word_ff   <= pend_word_in;
      rsp_ok_ff      <= rsp_ok_in;
      rsp_word_ff    <= rsp_word_in;
      rsp_entries_ff <= rsp_entries_in;
   end

   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.ok       = rsp_ok_ff;
   assign rsp_if.word_out = rsp_word_ff;
   assign rsp_if.entries  = rsp_entries_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(CAPACITY))
      else $error("entry count exceeds capacity");

   a_no_same_entry: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re && (mem_waddr == mem_raddr)))
      else $error("read and write of the same entry in one cycle");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_if.opcode == OP_CLEAR)) |=> (fill_ff == '0))
      else $error("clear left entries in the list");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_if.ready) |=> $stable(rsp_word_ff) && $stable(rsp_entries_ff))
      else $error("pending response overwritten");

endmodule

// File: rtl/core/isl_store.sv
// Entry storage: one write port and one registered read port.
module isl_store #(
   parameter int DEPTH = isl_pkg::CAPACITY_DEFAULT,
   parameter int WIDTH = isl_pkg::WORD_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   import isl_pkg::*;

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
